### sv/assert_macros.svh
// assertion macros included by the queue manager core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define LQM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define LQM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/lqm_pkg.sv
// shared types and constants of the linked task queue manager
package lqm_pkg;

	localparam int NUM_TASKS_DEF  = 64;
	localparam int NUM_QUEUES_DEF = 8;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_DEQ  = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK         = 2'd0,
		STS_EMPTY      = 2'd1,
		STS_NOT_QUEUED = 2'd2,
		STS_REJECTED   = 2'd3
	} status_t;

endpackage

### sv/linked_task_queue_manager_core.sv
// Linked task queue manager: NUM_QUEUES circular doubly linked queues over NUM_TASKS task
// numbers, one result word per command word. Per-task links and owner live in a task ram
// with one write and one registered read port, queue heads in a small queue ram with
// flip-flop valid bits. Commands run one at a time and the block takes the next command
// while the previous result still waits at the output. A rejected push, a pop of an empty
// queue, a dequeue of an unqueued task, a no-op or a push onto an empty queue goes from the
// lookup state straight to the response state; removing the only task of a queue adds the
// task unlink step, a push onto a non-empty queue the head, new word and tail steps, and
// removing a task from a queue of two or more the unlink, prev, reread and next steps. The
// sequence of task ram accesses sets these steps, and a result word that still waits at the
// output holds the next result word in the response state. After reset a clearing pass
// writes every task ram entry; no command is accepted during it.
`include "assert_macros.svh"

module linked_task_queue_manager_core import lqm_pkg::*; #(
	parameter int NUM_TASKS  = NUM_TASKS_DEF,
	parameter int NUM_QUEUES = NUM_QUEUES_DEF,
	localparam int TW = $clog2(NUM_TASKS),
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    opcode,
	input  logic [QW-1:0] queue_id,
	input  logic [TW-1:0] task_id,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [TW-1:0] result_task,
	output logic [QW-1:0] source_queue,
	output logic [1:0]    status
);

	typedef struct packed {
		logic          vld;
		logic [QW-1:0] owner;
		logic [TW-1:0] prev;
		logic [TW-1:0] next;
	} tword_t;

	localparam int TWORD_W = $bits(tword_t);

	typedef enum logic [10:0] {
		S_CLEAR = 11'b000_0000_0001,
		S_IDLE  = 11'b000_0000_0010,
		S_LOOK  = 11'b000_0000_0100,
		S_PU_H  = 11'b000_0000_1000,
		S_PU_R  = 11'b000_0001_0000,
		S_PU_T  = 11'b000_0010_0000,
		S_UN_T  = 11'b000_0100_0000,
		S_UN_P  = 11'b000_1000_0000,
		S_UN_R  = 11'b001_0000_0000,
		S_UN_N  = 11'b010_0000_0000,
		S_RESP  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic [NUM_QUEUES-1:0] hv_q, hv_d;
	logic [TW-1:0] clr_q, clr_d;
	logic out_valid_q, out_valid_d;

	// command and working registers
	logic [1:0]    op_q, op_d;
	logic [QW-1:0] q_q, q_d, cq_q, cq_d;
	logic [TW-1:0] t_q, t_d, ct_q, ct_d, n_q, n_d, p_q, p_d;
	logic [TW-1:0] res_t_q, res_t_d;
	logic [QW-1:0] res_q_q, res_q_d;
	logic [1:0]    res_s_q, res_s_d;
	logic [TW-1:0] result_task_q;
	logic [QW-1:0] source_queue_q;
	logic [1:0]    status_q;
	logic          load_out;

	// ram ports
	logic               t_we;
	logic [TW-1:0]      t_wa, t_ra;
	tword_t             t_wd, tw;
	logic [TWORD_W-1:0] t_rd;
	logic               q_we;
	logic [QW-1:0]      q_wa, q_ra;
	logic [TW-1:0]      q_wd, hd;

	logic q_ok, t_ok;

	assign tw   = tword_t'(t_rd);
	assign q_ok = (32'(q_q) < 32'(NUM_QUEUES));
	assign t_ok = (32'(t_q) < 32'(NUM_TASKS));

	lqm_ram #(
		.WIDTH (TWORD_W),
		.DEPTH (NUM_TASKS)
	) u_task_ram (
		.clk     (clk),
		.wr_en   (t_we),
		.wr_addr (t_wa),
		.wr_data (TWORD_W'(t_wd)),
		.rd_addr (t_ra),
		.rd_data (t_rd)
	);

	lqm_ram #(
		.WIDTH (TW),
		.DEPTH (NUM_QUEUES)
	) u_queue_ram (
		.clk     (clk),
		.wr_en   (q_we),
		.wr_addr (q_wa),
		.wr_data (q_wd),
		.rd_addr (q_ra),
		.rd_data (hd)
	);

	always_comb begin
		tword_t mod;
		mod         = tw;
		state_d     = state_q;
		hv_d        = hv_q;
		clr_d       = clr_q;
		op_d        = op_q;
		q_d         = q_q;
		t_d         = t_q;
		cq_d        = cq_q;
		ct_d        = ct_q;
		n_d         = n_q;
		p_d         = p_q;
		res_t_d     = res_t_q;
		res_q_d     = res_q_q;
		res_s_d     = res_s_q;
		load_out    = 1'b0;
		t_we        = 1'b0;
		t_wa        = t_q;
		t_wd        = '0;
		t_ra        = t_q;
		q_we        = 1'b0;
		q_wa        = q_q;
		q_wd        = t_q;
		q_ra        = q_q;
		unique case (state_q)
			S_CLEAR: begin
				t_we  = 1'b1;
				t_wa  = clr_q;
				clr_d = clr_q + 1'b1;
				if (clr_q == TW'(NUM_TASKS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				t_ra = task_id;
				q_ra = queue_id;
				if (in_valid) begin
					op_d    = opcode;
					q_d     = queue_id;
					t_d     = task_id;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				res_t_d = t_q;
				res_q_d = q_q;
				res_s_d = STS_OK;
				state_d = S_RESP;
				unique case (op_t'(op_q))
					OP_PUSH: begin
						res_s_d = STS_REJECTED;
						if (!q_ok || !t_ok) begin
							res_q_d = q_q;
						end else if (tw.vld) begin
							res_q_d = tw.owner;
						end else if (hv_q[q_q]) begin
							// append before the head: fetch the head word first
							n_d     = hd;
							t_ra    = hd;
							state_d = S_PU_H;
						end else begin
							t_we    = 1'b1;
							t_wd    = '{vld: 1'b1, owner: q_q, prev: t_q, next: t_q};
							q_we    = 1'b1;
							hv_d[q_q] = 1'b1;
							res_s_d = STS_OK;
						end
					end
					OP_POP: begin
						if (!q_ok || !hv_q[q_q]) begin
							res_t_d = '0;
							res_s_d = STS_EMPTY;
						end else begin
							ct_d    = hd;
							cq_d    = q_q;
							t_ra    = hd;
							state_d = S_UN_T;
						end
					end
					OP_DEQ: begin
						if (!t_ok || !tw.vld) begin
							res_q_d = '0;
							res_s_d = STS_NOT_QUEUED;
						end else begin
							ct_d    = t_q;
							cq_d    = tw.owner;
							q_ra    = tw.owner;
							state_d = S_UN_T;
						end
					end
					OP_NOP: begin
						res_s_d = STS_OK;
					end
					default: begin
						res_s_d = STS_OK;
					end
				endcase
			end
			S_PU_H: begin
				// tw is the head word, its prev is the tail
				p_d      = tw.prev;
				mod.prev = t_q;
				t_we     = 1'b1;
				t_wa     = n_q;
				t_wd     = mod;
				state_d  = S_PU_R;
			end
			S_PU_R: begin
				t_ra    = p_q;
				t_we    = 1'b1;
				t_wd    = '{vld: 1'b1, owner: q_q, prev: p_q, next: n_q};
				state_d = S_PU_T;
			end
			S_PU_T: begin
				mod.next = t_q;
				t_we     = 1'b1;
				t_wa     = p_q;
				t_wd     = mod;
				res_t_d  = t_q;
				res_q_d  = q_q;
				res_s_d  = STS_OK;
				state_d  = S_RESP;
			end
			S_UN_T: begin
				n_d     = tw.next;
				p_d     = tw.prev;
				res_t_d = ct_q;
				res_q_d = cq_q;
				res_s_d = STS_OK;
				t_we    = 1'b1;
				t_wa    = ct_q;
				if (tw.next == ct_q) begin
					// only task on the queue
					hv_d[cq_q] = 1'b0;
					state_d    = S_RESP;
				end else begin
					if (hd == ct_q) begin
						q_we = 1'b1;
						q_wa = cq_q;
						q_wd = tw.next;
					end
					t_ra    = tw.prev;
					state_d = S_UN_P;
				end
			end
			S_UN_P: begin
				mod.next = n_q;
				t_we     = 1'b1;
				t_wa     = p_q;
				t_wd     = mod;
				state_d  = S_UN_R;
			end
			S_UN_R: begin
				// read after the write above, next and prev may be the same task
				t_ra    = n_q;
				state_d = S_UN_N;
			end
			S_UN_N: begin
				mod.prev = p_q;
				t_we     = 1'b1;
				t_wa     = n_q;
				t_wd     = mod;
				state_d  = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (load_out) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			hv_q        <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			hv_q        <= hv_d;
			clr_q       <= clr_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q    <= op_d;
		q_q     <= q_d;
		t_q     <= t_d;
		cq_q    <= cq_d;
		ct_q    <= ct_d;
		n_q     <= n_d;
		p_q     <= p_d;
		res_t_q <= res_t_d;
		res_q_q <= res_q_d;
		res_s_q <= res_s_d;
		if (load_out) begin
			result_task_q  <= res_t_q;
			source_queue_q <= res_q_q;
			status_q       <= res_s_q;
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign result_task  = result_task_q;
	assign source_queue = source_queue_q;
	assign status       = status_q;

	`LQM_ASSERT_ALWAYS(a_no_accept_in_clear, (state_q == S_CLEAR) |-> !in_ready, "accept during clearing pass")
	`LQM_ASSERT(a_one_word_at_a_time, (in_valid && in_ready) |=> !in_ready, "second word taken while busy")
	`LQM_ASSERT(a_head_set_by_push, ((hv_q & ~$past(hv_q)) != '0) |-> ($past(op_q) == OP_PUSH), "queue filled without push")
	`LQM_ASSERT(a_out_from_resp, $rose(out_valid) |-> $past(state_q == S_RESP), "result word outside response state")

endmodule

### sv/lqm_ram.sv
// generic single write port ram with one registered read port
module lqm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### tb/tb_linked_task_queue_manager_core.sv
// testbench for the linked task queue manager core: directed and random command words
`timescale 1ns / 100ps

module tb_linked_task_queue_manager_core import lqm_pkg::*;;

	localparam int TW = $clog2(NUM_TASKS_DEF);
	localparam int QW = $clog2(NUM_QUEUES_DEF);

	typedef struct {
		logic [TW-1:0] res_task;
		logic [QW-1:0] res_queue;
		status_t       res_status;
	} queue_result_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [1:0]    opcode = OP_NOP;
	logic [QW-1:0] queue_id = '0;
	logic [TW-1:0] task_id = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [TW-1:0] result_task;
	logic [QW-1:0] source_queue;
	logic [1:0]    status;

	// shadow copy of the queue rings
	logic [TW-1:0] link_next [NUM_TASKS_DEF];
	logic [TW-1:0] link_prev [NUM_TASKS_DEF];
	bit            task_owned [NUM_TASKS_DEF];
	logic [QW-1:0] task_queue [NUM_TASKS_DEF];
	logic [TW-1:0] queue_head [NUM_QUEUES_DEF];
	bit            queue_busy [NUM_QUEUES_DEF];
	int            owned_count = 0;

	queue_result_t awaited_results [$];
	int            error_count = 0;
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;

	linked_task_queue_manager_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.queue_id     (queue_id),
		.task_id      (task_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_task  (result_task),
		.source_queue (source_queue),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic void detach_task(logic [TW-1:0] t, logic [QW-1:0] q);
		logic [TW-1:0] n;
		logic [TW-1:0] p;
		n = link_next[t];
		p = link_prev[t];
		if (n == t) begin
			queue_busy[q] = 1'b0;
		end else begin
			if (queue_head[q] == t) begin
				queue_head[q] = n;
			end
			link_next[p] = n;
			link_prev[n] = p;
		end
		task_owned[t] = 1'b0;
		owned_count--;
	endfunction

	function automatic queue_result_t apply_command(op_t op, logic [QW-1:0] q, logic [TW-1:0] t);
		queue_result_t r;
		logic [TW-1:0] h;
		logic [TW-1:0] tl;
		r.res_task = t;
		r.res_queue = q;
		r.res_status = STS_OK;
		case (op)
			OP_PUSH: begin
				if (task_owned[t]) begin
					r.res_queue = task_queue[t];
					r.res_status = STS_REJECTED;
				end else begin
					task_owned[t] = 1'b1;
					task_queue[t] = q;
					owned_count++;
					if (queue_busy[q]) begin
						// new task goes in just before the head, i.e. becomes the tail
						h = queue_head[q];
						tl = link_prev[h];
						link_next[tl] = t;
						link_prev[t] = tl;
						link_prev[h] = t;
						link_next[t] = h;
					end else begin
						queue_busy[q] = 1'b1;
						queue_head[q] = t;
						link_next[t] = t;
						link_prev[t] = t;
					end
				end
			end
			OP_POP: begin
				if (!queue_busy[q]) begin
					r.res_task = '0;
					r.res_status = STS_EMPTY;
				end else begin
					h = queue_head[q];
					r.res_task = h;
					detach_task(h, q);
				end
			end
			OP_DEQ: begin
				if (!task_owned[t]) begin
					r.res_queue = '0;
					r.res_status = STS_NOT_QUEUED;
				end else begin
					r.res_queue = task_queue[t];
					detach_task(t, task_queue[t]);
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		error_count++;
	endtask

	// starts and returns at a falling edge; valid stays high for the next word
	task automatic send_command(op_t op, logic [QW-1:0] q, logic [TW-1:0] t);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		queue_id = q;
		task_id = t;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		awaited_results.push_back(apply_command(op, q, t));
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result word, task", int'(result_task), 0);
			end else begin
				want = awaited_results.pop_front();
				if (result_task !== want.res_task)
					report_mismatch("result_task", int'(result_task), int'(want.res_task));
				if (source_queue !== want.res_queue)
					report_mismatch("source_queue", int'(source_queue), int'(want.res_queue));
				if (status !== want.res_status)
					report_mismatch("status", int'(status), int'(want.res_status));
			end
		end
	end

	function automatic logic [TW-1:0] draw_task(bit owned);
		logic [TW-1:0] t;
		t = TW'($urandom_range(0, NUM_TASKS_DEF - 1));
		for (int i = 0; i < 64 && task_owned[t] != owned; i++) begin
			t = TW'($urandom_range(0, NUM_TASKS_DEF - 1));
		end
		return t;
	endfunction

	// mostly the two low queues, so some rings grow long
	function automatic logic [QW-1:0] draw_queue(bit busy_only);
		logic [QW-1:0] q;
		q = ($urandom_range(0, 3) == 0) ? QW'($urandom_range(0, NUM_QUEUES_DEF - 1)) :
			QW'($urandom_range(0, 1));
		for (int i = 0; i < 32 && busy_only && !queue_busy[q]; i++) begin
			q = QW'($urandom_range(0, NUM_QUEUES_DEF - 1));
		end
		return q;
	endfunction

	task automatic test_idle_queue_ops();
		send_command(OP_POP, 3'd7, 6'd0);
		send_command(OP_DEQ, 3'd7, 6'd63);
		send_command(OP_NOP, 3'd7, 6'd63);
		send_command(OP_NOP, 3'd0, 6'd0);
	endtask

	task automatic test_push_pop_order();
		send_command(OP_PUSH, 3'd0, 6'd0);
		send_command(OP_PUSH, 3'd0, 6'd63);
		send_command(OP_PUSH, 3'd0, 6'd5);
		// already queued tasks are rejected, reporting the owning queue
		send_command(OP_PUSH, 3'd0, 6'd0);
		send_command(OP_PUSH, 3'd7, 6'd63);
		send_command(OP_POP, 3'd0, 6'd63);
		send_command(OP_POP, 3'd0, 6'd0);
		send_command(OP_POP, 3'd0, 6'd0);
		send_command(OP_POP, 3'd0, 6'd0);
	endtask

	task automatic test_dequeue_positions();
		send_command(OP_PUSH, 3'd7, 6'd10);
		send_command(OP_PUSH, 3'd7, 6'd11);
		send_command(OP_PUSH, 3'd7, 6'd12);
		send_command(OP_PUSH, 3'd7, 6'd13);
		send_command(OP_DEQ, 3'd0, 6'd12);
		send_command(OP_DEQ, 3'd3, 6'd10);
		send_command(OP_DEQ, 3'd0, 6'd13);
		send_command(OP_DEQ, 3'd0, 6'd11);
		send_command(OP_DEQ, 3'd0, 6'd11);
		send_command(OP_POP, 3'd7, 6'd0);
	endtask

	task automatic test_random_traffic(int count);
		int pick;
		int push_share;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			push_share = (owned_count < 24) ? 50 : 30;
			if (pick < 10) begin
				send_command(op_t'(2'($urandom_range(0, 3))),
					QW'($urandom_range(0, NUM_QUEUES_DEF - 1)),
					TW'($urandom_range(0, NUM_TASKS_DEF - 1)));
			end else if (pick < 10 + push_share) begin
				send_command(OP_PUSH, draw_queue(1'b0), draw_task(1'b0));
			end else if (pick < 30 + push_share) begin
				send_command(OP_POP, draw_queue(1'b1), TW'($urandom_range(0, NUM_TASKS_DEF - 1)));
			end else begin
				send_command(OP_DEQ, QW'($urandom_range(0, NUM_QUEUES_DEF - 1)), draw_task(1'b1));
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 14;
		recv_idle_pct = 54;
		test_idle_queue_ops();
		test_push_pop_order();
		test_dequeue_positions();
		test_random_traffic(200);

		send_idle_pct = 54;
		recv_idle_pct = 14;
		test_random_traffic(200);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(200);

		in_valid = 1'b0;
		wait (awaited_results.size() == 0);
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/lqm_pkg.sv
sv/lqm_ram.sv
sv/linked_task_queue_manager_core.sv
tb/tb_linked_task_queue_manager_core.sv
